// File: sv/lav_pkg.sv
package lav_pkg;

    // Fixed-point format of the inputs and of the internal unit axes
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int DIFF_W     = IN_W + 1;
    localparam int UNIT_W     = FRAC_BITS + 2;
    localparam int NORM_W     = FRAC_BITS + 34;
    localparam int TW         = 2 * UNIT_W;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int UNIT_ONE   = 1 << FRAC_BITS;

    // Output format
    localparam int OUT_FRAC  = 16;
    localparam int OUT_COL_W = 18;
    localparam int OFF_W     = 32;
    localparam int ROW_W     = 2;
    localparam int OUT_DN    = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int OUT_UP    = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int OUT_HALF  = (1 << OUT_DN) >> 1;
    localparam int EXT_W     = UNIT_W + OUT_UP + 1;

    // Offset datapath
    localparam int PRD_W = UNIT_W + IN_W;
    localparam int SUM_W = PRD_W + 2;

    // Normalizer
    localparam int MAG_W     = 30;
    localparam int POS_W     = $clog2(NORM_W);
    localparam int SQ_W      = 2 * MAG_W + 2;
    localparam int LEN_W     = MAG_W + 1;
    localparam int REM_W     = LEN_W + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = Q_W;
    localparam int NORM_LAT  = 5 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1;

    // Input register, two normalizers, side cross, up cross, offset
    localparam int PIPE_LAT = 1 + 2 * NORM_LAT + 2 + 3 + 3;

endpackage

// File: sv/look_at_view_matrix.sv
// View matrix from eye, target and up vector. Each accepted request yields three
// result rows (side axis, true up axis, back direction), each with three Q1.16 axis
// entries and a saturated Q16.16 offset of minus axis dot eye. The two normalizers
// each run a 31-stage square root and a FRAC_BITS+1 stage divide. The pipeline
// takes one request per cycle while it is not stalled, but the single output port
// hands out three rows per request, so the output limits the sustained request
// rate. Backpressure on the output stalls the whole pipeline.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [IN_W-1:0]      i_eye_x,
    input  logic signed [IN_W-1:0]      i_eye_y,
    input  logic signed [IN_W-1:0]      i_eye_z,
    input  logic signed [IN_W-1:0]      i_aim_x,
    input  logic signed [IN_W-1:0]      i_aim_y,
    input  logic signed [IN_W-1:0]      i_aim_z,
    input  logic signed [IN_W-1:0]      i_up_x,
    input  logic signed [IN_W-1:0]      i_up_y,
    input  logic signed [IN_W-1:0]      i_up_z,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ROW_W-1:0]            o_row_index,
    output logic signed [OUT_COL_W-1:0] o_col0,
    output logic signed [OUT_COL_W-1:0] o_col1,
    output logic signed [OUT_COL_W-1:0] o_col2,
    output logic signed [OFF_W-1:0]     o_offset,
    output logic                        o_degenerate,
    output logic                        o_last_row
);

    logic                    w_en;
    logic                    w_load_ok;
    logic [PIPE_LAT-1:0]     r_vld;

    logic signed [IN_W-1:0]   w_eye [3];
    logic signed [IN_W-1:0]   w_aim [3];
    logic signed [IN_W-1:0]   w_up  [3];

    logic signed [DIFF_W-1:0] r_p0_d  [3];
    logic signed [IN_W-1:0]   r_p0_e  [3];
    logic signed [IN_W-1:0]   r_p0_up [3];
    logic signed [NORM_W-1:0] w_n1_in [3];
    logic signed [UNIT_W-1:0] w_b     [3];
    logic                     w_ok1;

    logic signed [IN_W-1:0]   r_d1_e  [NORM_LAT][3];
    logic signed [IN_W-1:0]   r_d1_up [NORM_LAT][3];

    logic signed [NORM_W-1:0] r_c1_p  [6];
    logic signed [IN_W-1:0]   r_c1_e  [3];
    logic signed [UNIT_W-1:0] r_c1_b  [3];
    logic                     r_c1_ok;
    logic signed [NORM_W-1:0] r_c2_sv [3];
    logic signed [IN_W-1:0]   r_c2_e  [3];
    logic signed [UNIT_W-1:0] r_c2_b  [3];
    logic                     r_c2_ok;

    logic signed [UNIT_W-1:0] w_s [3];
    logic                     w_ok2;
    logic signed [IN_W-1:0]   r_d2_e  [NORM_LAT][3];
    logic signed [UNIT_W-1:0] r_d2_b  [NORM_LAT][3];
    logic                     r_d2_ok [NORM_LAT];

    logic signed [TW-1:0]     r_t1_p  [6];
    logic signed [IN_W-1:0]   r_t1_e  [3];
    logic signed [UNIT_W-1:0] r_t1_b  [3];
    logic signed [UNIT_W-1:0] r_t1_s  [3];
    logic                     r_t1_ok;
    logic signed [TW-1:0]     r_t2_d  [3];
    logic signed [IN_W-1:0]   r_t2_e  [3];
    logic signed [UNIT_W-1:0] r_t2_b  [3];
    logic signed [UNIT_W-1:0] r_t2_s  [3];
    logic                     r_t2_ok;
    logic signed [UNIT_W-1:0] r_t3_row [3][3];
    logic signed [IN_W-1:0]   r_t3_e  [3];
    logic                     r_t3_ok;
    logic signed [UNIT_W-1:0] n_t3_t  [3];

    logic signed [OUT_COL_W-1:0] w_col [3][3];
    logic signed [OFF_W-1:0]     w_off [3];
    logic                        w_deg;

    assign w_eye = '{i_eye_x, i_eye_y, i_eye_z};
    assign w_aim = '{i_aim_x, i_aim_y, i_aim_z};
    assign w_up  = '{i_up_x, i_up_y, i_up_z};

    // Whole pipeline moves unless the last stage is full and the output cannot take it
    assign w_en       = !r_vld[PIPE_LAT-1] || w_load_ok;
    assign o_in_ready = w_en;

    // Valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // Input register: eye minus target
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p0_d[i]  <= DIFF_W'(w_eye[i]) - DIFF_W'(w_aim[i]);
                r_p0_e[i]  <= w_eye[i];
                r_p0_up[i] <= w_up[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n1_in[i] = NORM_W'(r_p0_d[i]);
        end
    end

    // Back direction
    lav_norm u_norm_back (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (w_n1_in),
        .o_unit (w_b),
        .o_ok   (w_ok1)
    );

    // Carry eye and up alongside the first normalizer
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_e[0]  <= r_p0_e;
            r_d1_up[0] <= r_p0_up;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_d1_e[k]  <= r_d1_e[k-1];
                r_d1_up[k] <= r_d1_up[k-1];
            end
        end
    end

    // Up cross back
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_p[0] <= NORM_W'(r_d1_up[NORM_LAT-1][1]) * NORM_W'(w_b[2]);
            r_c1_p[1] <= NORM_W'(r_d1_up[NORM_LAT-1][2]) * NORM_W'(w_b[1]);
            r_c1_p[2] <= NORM_W'(r_d1_up[NORM_LAT-1][2]) * NORM_W'(w_b[0]);
            r_c1_p[3] <= NORM_W'(r_d1_up[NORM_LAT-1][0]) * NORM_W'(w_b[2]);
            r_c1_p[4] <= NORM_W'(r_d1_up[NORM_LAT-1][0]) * NORM_W'(w_b[1]);
            r_c1_p[5] <= NORM_W'(r_d1_up[NORM_LAT-1][1]) * NORM_W'(w_b[0]);
            r_c1_e  <= r_d1_e[NORM_LAT-1];
            r_c1_b  <= w_b;
            r_c1_ok <= w_ok1;
            for (int i = 0; i < 3; i++) begin
                r_c2_sv[i] <= r_c1_p[2*i] - r_c1_p[2*i+1];
            end
            r_c2_e  <= r_c1_e;
            r_c2_b  <= r_c1_b;
            r_c2_ok <= r_c1_ok;
        end
    end

    // Side axis
    lav_norm u_norm_side (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_c2_sv),
        .o_unit (w_s),
        .o_ok   (w_ok2)
    );

    // Carry eye, back and its flag alongside the second normalizer
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_e[0]  <= r_c2_e;
            r_d2_b[0]  <= r_c2_b;
            r_d2_ok[0] <= r_c2_ok;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_d2_e[k]  <= r_d2_e[k-1];
                r_d2_b[k]  <= r_d2_b[k-1];
                r_d2_ok[k] <= r_d2_ok[k-1];
            end
        end
    end

    // Round and clamp the true up axis
    always_comb begin
        logic [TW-1:0] v_mag;
        logic [TW-1:0] v_mr;
        logic [UNIT_W-1:0] v_c;
        for (int i = 0; i < 3; i++) begin
            v_mag = r_t2_d[i][TW-1] ? TW'(-r_t2_d[i]) : TW'(r_t2_d[i]);
            v_mr  = (v_mag + TW'(ROUND_HALF)) >> FRAC_BITS;
            if (v_mr > TW'(UNIT_ONE)) v_mr = TW'(UNIT_ONE);
            v_c   = v_mr[UNIT_W-1:0];
            n_t3_t[i] = r_t2_d[i][TW-1] ? signed'(-v_c) : signed'(v_c);
        end
    end

    // Back cross side
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_p[0] <= TW'(r_d2_b[NORM_LAT-1][1]) * TW'(w_s[2]);
            r_t1_p[1] <= TW'(r_d2_b[NORM_LAT-1][2]) * TW'(w_s[1]);
            r_t1_p[2] <= TW'(r_d2_b[NORM_LAT-1][2]) * TW'(w_s[0]);
            r_t1_p[3] <= TW'(r_d2_b[NORM_LAT-1][0]) * TW'(w_s[2]);
            r_t1_p[4] <= TW'(r_d2_b[NORM_LAT-1][0]) * TW'(w_s[1]);
            r_t1_p[5] <= TW'(r_d2_b[NORM_LAT-1][1]) * TW'(w_s[0]);
            r_t1_e  <= r_d2_e[NORM_LAT-1];
            r_t1_b  <= r_d2_b[NORM_LAT-1];
            r_t1_s  <= w_s;
            r_t1_ok <= r_d2_ok[NORM_LAT-1] && w_ok2;
            for (int i = 0; i < 3; i++) begin
                r_t2_d[i] <= r_t1_p[2*i] - r_t1_p[2*i+1];
            end
            r_t2_e  <= r_t1_e;
            r_t2_b  <= r_t1_b;
            r_t2_s  <= r_t1_s;
            r_t2_ok <= r_t1_ok;
            r_t3_row[0] <= r_t2_s;
            r_t3_row[1] <= n_t3_t;
            r_t3_row[2] <= r_t2_b;
            r_t3_e      <= r_t2_e;
            r_t3_ok     <= r_t2_ok;
        end
    end

    // Columns and offsets
    lav_offset u_offset (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_row (r_t3_row),
        .i_eye (r_t3_e),
        .i_ok  (r_t3_ok),
        .o_col (w_col),
        .o_off (w_off),
        .o_deg (w_deg)
    );

    // Hand out three rows per request
    lav_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_vld[PIPE_LAT-1]),
        .o_load_ok    (w_load_ok),
        .i_col        (w_col),
        .i_off        (w_off),
        .i_deg        (w_deg),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_offset     (o_offset),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );

endmodule

// File: sv/lav_norm.sv
module lav_norm
    import lav_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [NORM_W-1:0] i_vec  [3],
    output logic signed [UNIT_W-1:0] o_unit [3],
    output logic                     o_ok
);

    logic [NORM_W-1:0] r_s1_mag [3];
    logic [2:0]        r_s1_neg;
    logic [NORM_W-1:0] r_s2_mag [3];
    logic [2:0]        r_s2_neg;
    logic [NORM_W-1:0] r_s2_max;
    logic [NORM_W-1:0] r_s3_mag [3];
    logic [2:0]        r_s3_neg;
    logic [POS_W-1:0]  r_s3_pos;
    logic              r_s3_zero;
    logic [MAG_W-1:0]  r_s4_mag [3];
    logic [2:0]        r_s4_neg;
    logic              r_s4_zero;
    logic [2*MAG_W-1:0] r_s5_sq [3];
    logic [MAG_W-1:0]  r_s5_mag [3];
    logic [2:0]        r_s5_neg;
    logic              r_s5_zero;

    logic [SQ_W-1:0]   r_sq_n    [SQ_STEPS+1];
    logic [SQ_W-1:0]   r_sq_r    [SQ_STEPS+1];
    logic [MAG_W-1:0]  r_sq_mag  [SQ_STEPS+1][3];
    logic [2:0]        r_sq_neg  [SQ_STEPS+1];
    logic              r_sq_zero [SQ_STEPS+1];
    logic [SQ_W-1:0]   n_sq_n    [SQ_STEPS];
    logic [SQ_W-1:0]   n_sq_r    [SQ_STEPS];

    logic [REM_W-1:0]  r_dv_rem  [DIV_STEPS+1][3];
    logic [Q_W-1:0]    r_dv_low  [DIV_STEPS+1][3];
    logic [Q_W-1:0]    r_dv_q    [DIV_STEPS+1][3];
    logic [LEN_W-1:0]  r_dv_len  [DIV_STEPS+1];
    logic [2:0]        r_dv_neg  [DIV_STEPS+1];
    logic              r_dv_zero [DIV_STEPS+1];
    logic [REM_W-1:0]  n_dv_rem  [DIV_STEPS][3];
    logic [Q_W-1:0]    n_dv_q    [DIV_STEPS][3];

    logic [NORM_W-1:0] n_s2_max;
    logic [POS_W-1:0]  n_s3_pos;
    logic [MAG_W-1:0]  n_s4_mag [3];
    logic [NUM_W-1:0]  n_num    [3];

    logic signed [UNIT_W-1:0] r_unit [3];
    logic                     r_ok;

    // Largest magnitude
    always_comb begin
        n_s2_max = r_s1_mag[0];
        if (r_s1_mag[1] > n_s2_max) n_s2_max = r_s1_mag[1];
        if (r_s1_mag[2] > n_s2_max) n_s2_max = r_s1_mag[2];
    end

    // Leading one of the largest magnitude
    always_comb begin
        n_s3_pos = '0;
        for (int j = 0; j < NORM_W; j++) begin
            if (r_s2_max[j]) n_s3_pos = POS_W'(j);
        end
    end

    // Scale so that the largest magnitude has its top bit at MAG_W-1
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_s3_pos > POS_W'(MAG_W - 1)) begin
                n_s4_mag[i] = MAG_W'(r_s3_mag[i] >> (r_s3_pos - POS_W'(MAG_W - 1)));
            end else begin
                n_s4_mag[i] = MAG_W'(r_s3_mag[i] << (POS_W'(MAG_W - 1) - r_s3_pos));
            end
        end
    end

    // Square root, one result bit per stage
    always_comb begin
        logic [SQ_W:0]   v_trial;
        logic [SQ_W-1:0] v_bit;
        for (int k = 0; k < SQ_STEPS; k++) begin
            v_bit   = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
            v_trial = {1'b0, r_sq_r[k]} + {1'b0, v_bit};
            if ({1'b0, r_sq_n[k]} >= v_trial) begin
                n_sq_n[k] = r_sq_n[k] - v_trial[SQ_W-1:0];
                n_sq_r[k] = (r_sq_r[k] >> 1) + v_bit;
            end else begin
                n_sq_n[k] = r_sq_n[k];
                n_sq_r[k] = r_sq_r[k] >> 1;
            end
        end
    end

    // Rounded numerator for the divide
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NUM_W'({r_sq_mag[SQ_STEPS][i], {FRAC_BITS{1'b0}}})
                     + NUM_W'(r_sq_r[SQ_STEPS][LEN_W-1:0] >> 1);
        end
    end

    // Restoring divide, one quotient bit per stage
    always_comb begin
        logic [REM_W-1:0] v_rr;
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int i = 0; i < 3; i++) begin
                v_rr = {r_dv_rem[k][i][REM_W-2:0], r_dv_low[k][i][Q_W-1]};
                if (v_rr >= {1'b0, r_dv_len[k]}) begin
                    n_dv_rem[k][i] = v_rr - {1'b0, r_dv_len[k]};
                    n_dv_q[k][i]   = {r_dv_q[k][i][Q_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[k][i] = v_rr;
                    n_dv_q[k][i]   = {r_dv_q[k][i][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        logic [UNIT_W-1:0] v_q;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_mag[i] <= i_vec[i][NORM_W-1] ? NORM_W'(-i_vec[i]) : NORM_W'(i_vec[i]);
                r_s1_neg[i] <= i_vec[i][NORM_W-1];
            end
            r_s2_mag  <= r_s1_mag;
            r_s2_neg  <= r_s1_neg;
            r_s2_max  <= n_s2_max;
            r_s3_mag  <= r_s2_mag;
            r_s3_neg  <= r_s2_neg;
            r_s3_pos  <= n_s3_pos;
            r_s3_zero <= (r_s2_max == '0);
            r_s4_mag  <= n_s4_mag;
            r_s4_neg  <= r_s3_neg;
            r_s4_zero <= r_s3_zero;
            for (int i = 0; i < 3; i++) begin
                r_s5_sq[i] <= (2*MAG_W)'(r_s4_mag[i]) * (2*MAG_W)'(r_s4_mag[i]);
            end
            r_s5_mag  <= r_s4_mag;
            r_s5_neg  <= r_s4_neg;
            r_s5_zero <= r_s4_zero;

            r_sq_n[0]    <= SQ_W'(r_s5_sq[0]) + SQ_W'(r_s5_sq[1]) + SQ_W'(r_s5_sq[2]);
            r_sq_r[0]    <= '0;
            r_sq_mag[0]  <= r_s5_mag;
            r_sq_neg[0]  <= r_s5_neg;
            r_sq_zero[0] <= r_s5_zero;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq_n[k+1]    <= n_sq_n[k];
                r_sq_r[k+1]    <= n_sq_r[k];
                r_sq_mag[k+1]  <= r_sq_mag[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
                r_sq_zero[k+1] <= r_sq_zero[k];
            end

            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= REM_W'(n_num[i] >> Q_W);
                r_dv_low[0][i] <= n_num[i][Q_W-1:0];
                r_dv_q[0][i]   <= '0;
            end
            r_dv_len[0]  <= r_sq_r[SQ_STEPS][LEN_W-1:0];
            r_dv_neg[0]  <= r_sq_neg[SQ_STEPS];
            r_dv_zero[0] <= r_sq_zero[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[k+1][i] <= n_dv_rem[k][i];
                    r_dv_low[k+1][i] <= r_dv_low[k][i] << 1;
                    r_dv_q[k+1][i]   <= n_dv_q[k][i];
                end
                r_dv_len[k+1]  <= r_dv_len[k];
                r_dv_neg[k+1]  <= r_dv_neg[k];
                r_dv_zero[k+1] <= r_dv_zero[k];
            end

            // Restore signs
            for (int i = 0; i < 3; i++) begin
                v_q = {1'b0, r_dv_q[DIV_STEPS][i]};
                r_unit[i] <= r_dv_neg[DIV_STEPS][i] ? signed'(-v_q) : signed'(v_q);
            end
            r_ok <= !r_dv_zero[DIV_STEPS];
        end
    end

    assign o_unit = r_unit;
    assign o_ok   = r_ok;

endmodule

// File: sv/lav_offset.sv
module lav_offset
    import lav_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [UNIT_W-1:0]    i_row [3][3],
    input  logic signed [IN_W-1:0]      i_eye [3],
    input  logic                        i_ok,
    output logic signed [OUT_COL_W-1:0] o_col [3][3],
    output logic signed [OFF_W-1:0]     o_off [3],
    output logic                        o_deg
);

    logic signed [PRD_W-1:0]     r_o1_p   [3][3];
    logic signed [OUT_COL_W-1:0] r_o1_col [3][3];
    logic                        r_o1_deg;
    logic signed [SUM_W-1:0]     r_o2_sum [3];
    logic signed [OUT_COL_W-1:0] r_o2_col [3][3];
    logic                        r_o2_deg;
    logic signed [OUT_COL_W-1:0] r_o3_col [3][3];
    logic signed [OFF_W-1:0]     r_o3_off [3];
    logic                        r_o3_deg;
    logic signed [OFF_W-1:0]     n_off    [3];

    // Convert an internal unit value to the output format
    function automatic logic signed [OUT_COL_W-1:0] to_out(
        input logic signed [UNIT_W-1:0] v
    );
        logic [UNIT_W-1:0]       mag;
        logic [UNIT_W-1:0]       mr;
        logic signed [EXT_W-1:0] w;
        mag = v[UNIT_W-1] ? UNIT_W'(-v) : UNIT_W'(v);
        mr  = (mag + UNIT_W'(OUT_HALF)) >> OUT_DN;
        w   = signed'(EXT_W'(mr));
        if (v[UNIT_W-1]) w = -w;
        w   = w <<< OUT_UP;
        return w[OUT_COL_W-1:0];
    endfunction

    // Round, negate and saturate the dot products
    always_comb begin
        logic [SUM_W-1:0]   v_mag;
        logic [SUM_W-1:0]   v_mr;
        logic signed [SUM_W:0] v_off;
        for (int r = 0; r < 3; r++) begin
            v_mag = r_o2_sum[r][SUM_W-1] ? SUM_W'(-r_o2_sum[r]) : SUM_W'(r_o2_sum[r]);
            v_mr  = (v_mag + SUM_W'(ROUND_HALF)) >> FRAC_BITS;
            v_off = r_o2_sum[r][SUM_W-1] ? signed'({1'b0, v_mr}) : -signed'({1'b0, v_mr});
            if (v_off[SUM_W:OFF_W-1] == '0 || v_off[SUM_W:OFF_W-1] == '1) begin
                n_off[r] = v_off[OFF_W-1:0];
            end else if (v_off[SUM_W]) begin
                n_off[r] = {1'b1, {(OFF_W-1){1'b0}}};
            end else begin
                n_off[r] = {1'b0, {(OFF_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [UNIT_W-1:0] v_sel;
        if (i_en) begin
            // Zero the rows of a degenerate request, form the products
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    v_sel = i_ok ? i_row[r][i] : '0;
                    r_o1_p[r][i]   <= PRD_W'(v_sel) * PRD_W'(i_eye[i]);
                    r_o1_col[r][i] <= to_out(v_sel);
                end
            end
            r_o1_deg <= !i_ok;
            // Sum each row
            for (int r = 0; r < 3; r++) begin
                r_o2_sum[r] <= SUM_W'(r_o1_p[r][0]) + SUM_W'(r_o1_p[r][1])
                             + SUM_W'(r_o1_p[r][2]);
            end
            r_o2_col <= r_o1_col;
            r_o2_deg <= r_o1_deg;
            r_o3_off <= n_off;
            r_o3_col <= r_o2_col;
            r_o3_deg <= r_o2_deg;
        end
    end

    assign o_col = r_o3_col;
    assign o_off = r_o3_off;
    assign o_deg = r_o3_deg;

endmodule

// File: sv/lav_serial.sv
module lav_serial
    import lav_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    output logic                        o_load_ok,
    input  logic signed [OUT_COL_W-1:0] i_col [3][3],
    input  logic signed [OFF_W-1:0]     i_off [3],
    input  logic                        i_deg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ROW_W-1:0]            o_row_index,
    output logic signed [OUT_COL_W-1:0] o_col0,
    output logic signed [OUT_COL_W-1:0] o_col1,
    output logic signed [OUT_COL_W-1:0] o_col2,
    output logic signed [OFF_W-1:0]     o_offset,
    output logic                        o_degenerate,
    output logic                        o_last_row
);

    localparam logic [ROW_W-1:0] ROW_SIDE = 2'd0;
    localparam logic [ROW_W-1:0] ROW_UP   = 2'd1;
    localparam logic [ROW_W-1:0] ROW_BACK = 2'd2;

    logic                        r_valid;
    logic [ROW_W-1:0]            r_cnt;
    logic signed [OUT_COL_W-1:0] r_col [3][3];
    logic signed [OFF_W-1:0]     r_off [3];
    logic                        r_deg;

    assign o_load_ok = !r_valid || (i_ready && r_cnt == ROW_BACK);

    // Hold one request's three rows, hand them out in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= ROW_SIDE;
        end else if (i_load && o_load_ok) begin
            r_valid <= 1'b1;
            r_cnt   <= ROW_SIDE;
        end else if (r_valid && i_ready) begin
            if (r_cnt == ROW_BACK) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ok) begin
            r_col <= i_col;
            r_off <= i_off;
            r_deg <= i_deg;
        end
    end

    // Select the current row
    always_comb begin
        case (r_cnt)
            ROW_SIDE: begin
                o_col0 = r_col[0][0]; o_col1 = r_col[0][1]; o_col2 = r_col[0][2];
                o_offset = r_off[0];
            end
            ROW_UP: begin
                o_col0 = r_col[1][0]; o_col1 = r_col[1][1]; o_col2 = r_col[1][2];
                o_offset = r_off[1];
            end
            default: begin
                o_col0 = r_col[2][0]; o_col1 = r_col[2][1]; o_col2 = r_col[2][2];
                o_offset = r_off[2];
            end
        endcase
    end

    assign o_valid      = r_valid;
    assign o_row_index  = r_cnt;
    assign o_degenerate = r_deg;
    assign o_last_row   = (r_cnt == ROW_BACK);

endmodule

// File: test/look_at_view_matrix_chk.sv
`timescale 1ns / 1ps

module look_at_view_matrix_chk
    import lav_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic signed [IN_W-1:0]      i_eye_x,
    input  logic signed [IN_W-1:0]      i_eye_y,
    input  logic signed [IN_W-1:0]      i_eye_z,
    input  logic signed [IN_W-1:0]      i_aim_x,
    input  logic signed [IN_W-1:0]      i_aim_y,
    input  logic signed [IN_W-1:0]      i_aim_z,
    input  logic signed [IN_W-1:0]      i_up_x,
    input  logic signed [IN_W-1:0]      i_up_y,
    input  logic signed [IN_W-1:0]      i_up_z,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [ROW_W-1:0]            i_row_index,
    input  logic signed [OUT_COL_W-1:0] i_col0,
    input  logic signed [OUT_COL_W-1:0] i_col1,
    input  logic signed [OUT_COL_W-1:0] i_col2,
    input  logic signed [OFF_W-1:0]     i_offset,
    input  logic                        i_degenerate,
    input  logic                        i_last_row,
    output int                          o_errors,
    output int                          o_pending
);

    typedef struct packed {
        logic [ROW_W-1:0]            row;
        logic signed [OUT_COL_W-1:0] c0;
        logic signed [OUT_COL_W-1:0] c1;
        logic signed [OUT_COL_W-1:0] c2;
        logic signed [OFF_W-1:0]     off;
        logic                        degen;
        logic                        last;
    } t_view_row;

    t_view_row rows_due[$];

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint m;
        if (s == 0) return v;
        m = (mag(v) + (longint'(1) << (s - 1))) / (longint'(1) << s);
        return v < 0 ? -m : m;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // scale into [2^29, 2^30), then divide by the integer length
    function automatic bit to_unit(input longint v[3], output longint u[3]);
        longint w[3];
        longint m, len, q;
        longint unsigned sq;
        m = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            w[i] = v[i];
            if (mag(w[i]) > m) m = mag(w[i]);
        end
        if (m == 0) return 0;
        while (m >= (longint'(1) << 30)) begin
            for (int i = 0; i < 3; i++) w[i] = w[i] / 2;
            m = m / 2;
        end
        while (m < (longint'(1) << 29)) begin
            for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
            m = m * 2;
        end
        for (int i = 0; i < 3; i++) sq += longint'(w[i] * w[i]);
        len = floor_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (mag(w[i]) * (longint'(1) << FRAC_BITS) + len / 2) / len;
            u[i] = w[i] < 0 ? -q : q;
        end
        return 1;
    endfunction

    function automatic longint clamp_one(longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        return v > one ? one : (v < -one ? -one : v);
    endfunction

    function automatic longint out_col(longint v);
        if (FRAC_BITS >= OUT_FRAC) return round_shift(v, FRAC_BITS - OUT_FRAC);
        return v * (longint'(1) << (OUT_FRAC - FRAC_BITS));
    endfunction

    // build the three view rows for one request
    task automatic predict_view(input longint e[3], input longint a[3], input longint up[3]);
        longint d[3], b[3], sv[3], s[3], t[3];
        longint ax[3][3];
        longint off;
        bit ok;
        t_view_row r;
        for (int i = 0; i < 3; i++) d[i] = e[i] - a[i];
        ok = to_unit(d, b);
        if (ok) begin
            sv[0] = up[1] * b[2] - up[2] * b[1];
            sv[1] = up[2] * b[0] - up[0] * b[2];
            sv[2] = up[0] * b[1] - up[1] * b[0];
            ok = to_unit(sv, s);
        end
        if (ok) begin
            t[0] = clamp_one(round_shift(b[1] * s[2] - b[2] * s[1], FRAC_BITS));
            t[1] = clamp_one(round_shift(b[2] * s[0] - b[0] * s[2], FRAC_BITS));
            t[2] = clamp_one(round_shift(b[0] * s[1] - b[1] * s[0], FRAC_BITS));
        end
        for (int i = 0; i < 3; i++) begin
            ax[0][i] = ok ? s[i] : 0;
            ax[1][i] = ok ? t[i] : 0;
            ax[2][i] = ok ? b[i] : 0;
        end
        for (int k = 0; k < 3; k++) begin
            off = 0;
            for (int i = 0; i < 3; i++) off += ax[k][i] * e[i];
            off = -round_shift(off, FRAC_BITS);
            if (off > 64'sd2147483647) off = 64'sd2147483647;
            if (off < -64'sd2147483648) off = -64'sd2147483648;
            r.row   = ROW_W'(k);
            r.c0    = OUT_COL_W'(out_col(ax[k][0]));
            r.c1    = OUT_COL_W'(out_col(ax[k][1]));
            r.c2    = OUT_COL_W'(out_col(ax[k][2]));
            r.off   = OFF_W'(off);
            r.degen = !ok;
            r.last  = (k == 2);
            rows_due.push_back(r);
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_view_row want, got;
        longint e[3], a[3], u[3];
        if (i_rst_n && i_in_valid && i_in_ready) begin
            e = '{i_eye_x, i_eye_y, i_eye_z};
            a = '{i_aim_x, i_aim_y, i_aim_z};
            u = '{i_up_x, i_up_y, i_up_z};
            predict_view(e, a, u);
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got = '{i_row_index, i_col0, i_col1, i_col2, i_offset, i_degenerate, i_last_row};
            if (rows_due.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) $display("unexpected row %p", got);
            end else begin
                want = rows_due.pop_front();
                if (want !== got) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("row mismatch: expected %p got %p", want, got);
                end
            end
        end
        o_pending <= rows_due.size();
    end

endmodule

// File: test/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps

module look_at_view_matrix_tb;
    import lav_pkg::*;

    localparam int N_RAND    = 200;
    localparam int STALL_CAP = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic i_out_ready = 0;
    logic signed [IN_W-1:0] i_eye_x = 0, i_eye_y = 0, i_eye_z = 0;
    logic signed [IN_W-1:0] i_aim_x = 0, i_aim_y = 0, i_aim_z = 0;
    logic signed [IN_W-1:0] i_up_x = 0, i_up_y = 0, i_up_z = 0;
    logic o_in_ready, o_out_valid, o_degenerate, o_last_row;
    logic [ROW_W-1:0] o_row_index;
    logic signed [OUT_COL_W-1:0] o_col0, o_col1, o_col2;
    logic signed [OFF_W-1:0] o_offset;
    int errors, pending, quiet;
    bit calm;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    look_at_view_matrix dut (.*);

    look_at_view_matrix_chk chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready),
        .i_eye_x, .i_eye_y, .i_eye_z, .i_aim_x, .i_aim_y, .i_aim_z,
        .i_up_x, .i_up_y, .i_up_z, .i_out_valid(o_out_valid), .i_out_ready,
        .i_row_index(o_row_index), .i_col0(o_col0), .i_col1(o_col1), .i_col2(o_col2),
        .i_offset(o_offset), .i_degenerate(o_degenerate), .i_last_row(o_last_row),
        .o_errors(errors), .o_pending(pending)
    );

    // stall the result side in short random bursts
    always @(posedge i_clk) begin
        int gap;
        if (calm || !i_rst_n) begin
            i_out_ready <= 1;
        end else if (!i_out_ready) begin
            i_out_ready <= 1;
        end else if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_out_ready <= 0;
            repeat (gap - 1) @(posedge i_clk);
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_CAP) begin
            $display("look_at_view_matrix regression: fail");
            $finish;
        end
    end

    // hold one request until it is accepted; drop valid only while idling
    task automatic send_request(input logic [IN_W-1:0] v[9]);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        {i_eye_x, i_eye_y, i_eye_z} <= {v[0], v[1], v[2]};
        {i_aim_x, i_aim_y, i_aim_z} <= {v[3], v[4], v[5]};
        {i_up_x, i_up_y, i_up_z} <= {v[6], v[7], v[8]};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return IN_W'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return IN_W'($signed($urandom_range(0, 20)) - 10) <<< 16;
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return IN_W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    initial begin
        logic [IN_W-1:0] v[9];
        localparam logic [31:0] MX = 32'h7fffffff, MN = 32'h80000000, ONE = 32'h10000;
        calm = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: plain camera, extremes, eye on target, parallel and zero up
        send_request('{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0});
        send_request('{MX, MX, MX, MN, MN, MN, 0, ONE, 0});
        send_request('{MN, MN, MN, MX, MX, MX, ONE, 0, 0});
        send_request('{MX, MN, MX, MN, MX, MN, MX, MN, MX});
        send_request('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
        send_request('{0, 0, ONE, 0, 0, 0, 0, 0, 7});
        send_request('{0, 0, ONE, 0, 0, 0, 0, 0, 0});
        send_request('{MX, 0, 0, 0, 0, 0, 0, ONE, 0});
        send_request('{MN, MN, MN, 0, 0, 0, MN, MN, MN});
        send_request('{1, 0, 0, 0, 0, 0, 0, 0, 1});
        send_request('{0, 0, 0, 0, 0, 1, MX, MX, MN});
        send_request('{MX, MX, MX, 0, 0, 0, 1, 0, 0});
        send_request('{32'hffffffff, 0, 0, 0, 0, 0, 0, 32'hffffffff, 0});
        for (int n = 0; n < N_RAND; n++) begin
            for (int i = 0; i < 9; i++) v[i] = pick_coord();
            if ($urandom_range(0, 15) == 0) v[3:5] = v[0:2];
            if ($urandom_range(0, 15) == 0) v[6:8] = '{0, 0, 0};
            if (n > N_RAND - 30) calm = 1;
            send_request(v);
        end
        i_in_valid <= 0;
        calm = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (errors == 0)
            $display("look_at_view_matrix regression: pass");
        else
            $display("look_at_view_matrix regression: fail");
        $finish;
    end

endmodule

// File: files.f
sv/lav_pkg.sv
sv/lav_norm.sv
sv/lav_offset.sv
sv/lav_serial.sv
sv/look_at_view_matrix.sv
test/look_at_view_matrix_chk.sv
test/look_at_view_matrix_tb.sv
